// ----- rtl/ffc_pkg.sv -----
// shared constants and types for the binary32/binary64 format converter
package ffc_pkg;

	// conversion direction codes
	localparam logic [1:0] MODE_S2D = 2'd0;
	localparam logic [1:0] MODE_D2S = 2'd1;
	localparam logic [1:0] MODE_S2S = 2'd2;
	localparam logic [1:0] MODE_D2D = 2'd3;

	localparam int SGL_FBITS = 23;
	localparam int DBL_FBITS = 52;
	localparam int SGL_EBITS = 8;
	localparam int DBL_EBITS = 11;
	localparam int SGL_BIAS  = 127;
	localparam int DBL_BIAS  = 1023;
	localparam int BIAS_DIFF = DBL_BIAS - SGL_BIAS;

	localparam int EXP_W   = 13;
	localparam int MANT_W  = DBL_FBITS + 1;
	localparam int EXT_W   = MANT_W + 2;
	localparam int SHAMT_W = 6;

	typedef logic signed [EXP_W-1:0] ffc_exp_t;

	typedef struct packed {
		logic sign;
		logic dst_dbl;
		logic is_nan;
		logic is_inf;
		logic is_zero;
	} ffc_ctrl_t;

endpackage

// ----- rtl/ffc_unpack.sv -----
// decode, leading-zero count and normalization with target rebias (stages 1 and 2)
module ffc_unpack import ffc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [1:0]             mode,
	input  logic [63:0]            operand,
	output logic                   v_s2,
	output ffc_ctrl_t              ctrl_s2,
	output logic [MANT_W-1:0]      mant_s2,
	output ffc_exp_t               exp_s2
);

	function automatic logic [SHAMT_W-1:0] lead_zeros(input logic [DBL_FBITS-1:0] v);
		logic [SHAMT_W-1:0] n;
		n = SHAMT_W'(DBL_FBITS);
		for (int i = 0; i < DBL_FBITS; i++) begin
			if (v[i])
				n = SHAMT_W'(DBL_FBITS - 1 - i);
		end
		return n;
	endfunction

	logic                   src_dbl;
	logic                   ones;
	logic [DBL_EBITS-1:0]   ef;
	logic [DBL_FBITS-1:0]   frac;
	ffc_ctrl_t              ctrl;

	logic                   v_s1;
	ffc_ctrl_t              ctrl_s1;
	logic [DBL_EBITS-1:0]   ef_s1;
	logic [DBL_FBITS-1:0]   frac_s1;
	logic [SHAMT_W-1:0]     lz_s1;
	logic                   sub_s1;
	logic                   src_dbl_s1;

	logic [DBL_FBITS-1:0]   norm;
	logic [MANT_W-1:0]      mant;
	ffc_exp_t               base;
	ffc_exp_t               adj;

	always_comb begin
		src_dbl = mode[0];
		if (src_dbl) begin
			ef   = operand[62:52];
			frac = operand[51:0];
			ones = &operand[62:52];
			ctrl.sign = operand[63];
		end else begin
			ef   = {3'b000, operand[30:23]};
			frac = {operand[22:0], 29'd0};
			ones = &operand[30:23];
			ctrl.sign = operand[31];
		end
		ctrl.dst_dbl = (mode == MODE_S2D) || (mode == MODE_D2D);
		ctrl.is_nan  = ones && (frac != '0);
		ctrl.is_inf  = ones && (frac == '0);
		ctrl.is_zero = (ef == '0) && (frac == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		ctrl_s1    <= ctrl;
		ef_s1      <= ef;
		frac_s1    <= frac;
		lz_s1      <= lead_zeros(frac);
		sub_s1     <= (ef == '0);
		src_dbl_s1 <= src_dbl;
	end

	// subnormal: shift the leading one up to the hidden-bit position
	always_comb begin
		norm = frac_s1 << lz_s1;
		mant = sub_s1 ? {norm, 1'b0} : {1'b1, frac_s1};
		base = sub_s1 ? -ffc_exp_t'({7'd0, lz_s1}) : ffc_exp_t'({2'b00, ef_s1});
		case ({src_dbl_s1, ctrl_s1.dst_dbl})
			2'b01:   adj = ffc_exp_t'(BIAS_DIFF);
			2'b10:   adj = ffc_exp_t'(-BIAS_DIFF);
			default: adj = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		ctrl_s2 <= ctrl_s1;
		mant_s2 <= mant;
		exp_s2  <= base + adj;
	end

endmodule

// ----- rtl/ffc_align.sv -----
// range check and right shift into the subnormal range with sticky collection (stage 3)
module ffc_align import ffc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   v_s2,
	input  ffc_ctrl_t              ctrl_s2,
	input  logic [MANT_W-1:0]      mant_s2,
	input  ffc_exp_t               exp_s2,
	output logic                   v_s3,
	output ffc_ctrl_t              ctrl_s3,
	output logic                   tiny_s3,
	output logic [DBL_EBITS-1:0]   ebase_s3,
	output logic [EXT_W-1:0]       shifted_s3,
	output logic                   sticky_s3
);

	logic                 in_norm;
	logic                 tiny;
	ffc_exp_t             r_full;
	ffc_exp_t             em1;
	logic [SHAMT_W-1:0]   shamt;
	logic [EXT_W-1:0]     ext;

	always_comb begin
		in_norm = exp_s2 > ffc_exp_t'(0);
		r_full  = ffc_exp_t'(1) - exp_s2;
		em1     = exp_s2 - ffc_exp_t'(1);
		// below half the smallest subnormal of the target
		tiny    = !in_norm && (ctrl_s2.dst_dbl ? (exp_s2 < ffc_exp_t'(-DBL_FBITS))
		                                      : (exp_s2 < ffc_exp_t'(-SGL_FBITS)));
		shamt   = (in_norm || tiny) ? '0 : r_full[SHAMT_W-1:0];
		ext     = {mant_s2, 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		ctrl_s3    <= ctrl_s2;
		tiny_s3    <= tiny;
		ebase_s3   <= in_norm ? em1[DBL_EBITS-1:0] : '0;
		shifted_s3 <= ext >> shamt;
		sticky_s3  <= |(ext & ~({EXT_W{1'b1}} << shamt));
	end

endmodule

// ----- rtl/ffc_round.sv -----
// round to nearest even, exponent assembly, overflow and special values (stage 4)
module ffc_round import ffc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   v_s3,
	input  ffc_ctrl_t              ctrl_s3,
	input  logic                   tiny_s3,
	input  logic [DBL_EBITS-1:0]   ebase_s3,
	input  logic [EXT_W-1:0]       shifted_s3,
	input  logic                   sticky_s3,
	output logic                   v_s4,
	output logic [63:0]            converted_s4
);

	logic [MANT_W-1:0]      kept_d;
	logic                   inc_d;
	logic [63:0]            sum_d;
	logic                   ovf_d;
	logic [SGL_FBITS:0]     kept_s;
	logic                   inc_s;
	logic [35:0]            sum_s;
	logic                   ovf_s;
	logic                   sign;
	logic [63:0]            res;

	always_comb begin
		kept_d = shifted_s3[54:2];
		inc_d  = shifted_s3[1] && (shifted_s3[0] || sticky_s3 || kept_d[0]);
		sum_d  = {1'b0, ebase_s3, 52'd0} + 64'(kept_d) + 64'(inc_d);
		ovf_d  = sum_d[63:52] >= 12'h7FF;

		kept_s = shifted_s3[54:31];
		inc_s  = shifted_s3[30] && ((|shifted_s3[29:0]) || sticky_s3 || kept_s[0]);
		sum_s  = {2'b00, ebase_s3, 23'd0} + 36'(kept_s) + 36'(inc_s);
		ovf_s  = sum_s[35:23] >= 13'd255;

		sign = ctrl_s3.sign;
		if (ctrl_s3.dst_dbl) begin
			if (ctrl_s3.is_nan)
				res = {sign, 11'h7FF, 1'b1, 51'd0};
			else if (ctrl_s3.is_inf)
				res = {sign, 11'h7FF, 52'd0};
			else if (ctrl_s3.is_zero || tiny_s3)
				res = {sign, 63'd0};
			else if (ovf_d)
				res = {sign, 11'h7FF, 52'd0};
			else
				res = {sign, sum_d[62:0]};
		end else begin
			if (ctrl_s3.is_nan)
				res = {32'd0, sign, 8'hFF, 1'b1, 22'd0};
			else if (ctrl_s3.is_inf)
				res = {32'd0, sign, 8'hFF, 23'd0};
			else if (ctrl_s3.is_zero || tiny_s3)
				res = {32'd0, sign, 31'd0};
			else if (ovf_s)
				res = {32'd0, sign, 8'hFF, 23'd0};
			else
				res = {32'd0, sign, sum_s[30:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		converted_s4 <= res;
	end

endmodule

// ----- rtl/float_format_convert.sv -----
// top level of the binary32/binary64 format converter
//
//  channel   signals                     handshake
//  input     start, busy, mode, operand  item taken when start && !busy
//  result    done, converted             one-cycle strobe, no back-pressure
//
// four register stages: decode and leading-zero count, normalize and rebias,
// align with sticky, round and pack; results leave in the order their items were taken
// one item per cycle sustained; busy stays low since nothing can stall the pipe
// reset clears the stage valid bits only; datapath registers are not reset
module float_format_convert import ffc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    mode,
	input  logic [63:0]   operand,
	output logic          done,
	output logic [63:0]   converted
);

	logic                   v_s2;
	ffc_ctrl_t              ctrl_s2;
	logic [MANT_W-1:0]      mant_s2;
	ffc_exp_t               exp_s2;

	logic                   v_s3;
	ffc_ctrl_t              ctrl_s3;
	logic                   tiny_s3;
	logic [DBL_EBITS-1:0]   ebase_s3;
	logic [EXT_W-1:0]       shifted_s3;
	logic                   sticky_s3;

	assign busy = 1'b0;

	ffc_unpack u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.mode     (mode),
		.operand  (operand),
		.v_s2     (v_s2),
		.ctrl_s2  (ctrl_s2),
		.mant_s2  (mant_s2),
		.exp_s2   (exp_s2)
	);

	ffc_align u_align (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_s2       (v_s2),
		.ctrl_s2    (ctrl_s2),
		.mant_s2    (mant_s2),
		.exp_s2     (exp_s2),
		.v_s3       (v_s3),
		.ctrl_s3    (ctrl_s3),
		.tiny_s3    (tiny_s3),
		.ebase_s3   (ebase_s3),
		.shifted_s3 (shifted_s3),
		.sticky_s3  (sticky_s3)
	);

	ffc_round u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s3         (v_s3),
		.ctrl_s3      (ctrl_s3),
		.tiny_s3      (tiny_s3),
		.ebase_s3     (ebase_s3),
		.shifted_s3   (shifted_s3),
		.sticky_s3    (sticky_s3),
		.v_s4         (done),
		.converted_s4 (converted)
	);

endmodule

// ----- rtl/ffc_checker.sv -----
// port-level checks for the format converter, bound to the top level
module ffc_checker import ffc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  logic [1:0]    mode,
	input  logic [63:0]   operand,
	input  logic          done,
	input  logic [63:0]   converted
);

	// every accepted item yields its result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result missing four cycles after an item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result strobe without a matching item");

	// single targets leave the upper word clear
	a_single_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(mode, 4) == MODE_D2S || $past(mode, 4) == MODE_S2S))
		|-> (converted[63:32] == 32'd0))
		else $error("single result with nonzero upper word");

	// single nan through single mode becomes the quiet nan with its sign
	a_quiet_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(mode, 4) == MODE_S2S && $past(operand[30:23], 4) == 8'hFF
		 && $past(operand[22:0], 4) != 23'd0)
		|-> (converted[31:0] == {$past(operand[31], 4), 8'hFF, 1'b1, 22'd0}))
		else $error("nan not turned into quiet nan");

endmodule

bind float_format_convert ffc_checker u_ffc_checker (.*);
